>>> rtl/siq_pkg.sv
// Shared types and command codes for the sorted insert queue.
`default_nettype none

package siq_pkg;

   typedef enum logic [1:0] {
      CMD_APPEND = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_INSERT = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   localparam int unsigned ValueWidth = 8;
   localparam int unsigned CountWidth = 4;

   typedef struct packed {
      cmd_type                command;
      logic [ValueWidth-1:0]  value;
   } req_type;

   typedef struct packed {
      logic [ValueWidth-1:0]  front_value;
      logic [CountWidth-1:0]  count;
      logic                   empty_res;
      logic                   full_res;
      logic                   refused;
   } rsp_type;

   // Operation broadcast to every cell; refused commands arrive as CMD_NONE.
   typedef struct packed {
      cmd_type                op;
      logic [ValueWidth-1:0]  value;
   } ctl_type;

endpackage

`default_nettype wire

>>> rtl/siq_cell.sv
// One queue slot: holds an entry and shifts to or from its neighbors.
`default_nettype none

module siq_cell #(
   parameter int unsigned DEPTH = 8,
   parameter int unsigned IDX   = 0
) (
   input  wire logic                            clock,
   input  wire siq_pkg::ctl_type                ctl,
   input  wire logic [$clog2(DEPTH+1)-1:0]      occ,
   input  wire logic [siq_pkg::ValueWidth-1:0]  prev_slot,
   input  wire logic [siq_pkg::ValueWidth-1:0]  next_slot,
   input  wire logic                            pass_in,
   output logic                                 pass_out,
   output logic [siq_pkg::ValueWidth-1:0]       slot_q,
   output logic [siq_pkg::ValueWidth-1:0]       slot_next
);
   import siq_pkg::*;

   localparam int unsigned CW = $clog2(DEPTH+1);

   logic [ValueWidth-1:0] slot_ff;
   logic [ValueWidth-1:0] slot_in;
   logic                  in_use;
   logic                  mine_pass;

   assign in_use    = CW'(IDX) < occ;
   // The new value goes past this entry only if it is strictly greater.
   assign mine_pass = in_use && (ctl.value > slot_ff);
   assign pass_out  = pass_in && mine_pass;

   always_comb begin
      slot_in = slot_ff;
      case (ctl.op)
         CMD_APPEND: begin
            if (occ == CW'(IDX)) slot_in = ctl.value;
         end
         CMD_REMOVE: begin
            slot_in = next_slot;
         end
         CMD_INSERT: begin
            if (pass_in && !mine_pass) begin
               slot_in = ctl.value;
            end else if (!pass_in) begin
               slot_in = prev_slot;
            end
         end
         default: begin
            slot_in = slot_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   assign slot_q    = slot_ff;
   assign slot_next = slot_in;

endmodule

`default_nettype wire

>>> rtl/sorted_insert_queue_unit.sv
// Top level of the sorted insert queue: a row of slot cells and the fill count.
//
// A bounded queue of byte entries, front first. A transaction is taken at a
// rising edge with start high and busy low; busy is always low, so one
// command may be issued every cycle. Commands: append at the rear, remove
// the front, or insert before the first entry not less than the value.
// Appends and inserts on a full queue, and removes on an empty one, leave
// the state alone and set refused.
// Exactly one result follows each transaction, on rsp_item with rsp_valid
// high for one cycle, in the cycle after the command. The insert position
// is found by a ripple of compares through the row of DEPTH cells, which
// all update in the same cycle.
// The result reports the front entry, the count, empty, full and refused,
// as seen after the command. The receiver cannot stall the result.
// Reset empties the queue; slot contents are left as they are.
`default_nettype none

module sorted_insert_queue_unit #(
   parameter int unsigned DEPTH = 8
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire siq_pkg::req_type req_item,
   output logic            rsp_valid,
   output siq_pkg::rsp_type rsp_item
);
   import siq_pkg::*;

   localparam int unsigned CW = $clog2(DEPTH+1);

   logic [CW-1:0]          occ_ff;
   logic [CW-1:0]          occ_in;
   logic                   valid_ff;
   rsp_type                rsp_ff;
   rsp_type                rsp_in;
   ctl_type                ctl;
   logic                   take;
   logic                   full;
   logic                   empty;
   logic                   refuse;
   logic [DEPTH:0]         pass;
   logic [ValueWidth-1:0]  slot_q    [DEPTH];
   logic [ValueWidth-1:0]  slot_next [DEPTH];

   assign busy  = 1'b0;
   assign take  = start && !busy;
   assign full  = occ_ff == CW'(DEPTH);
   assign empty = occ_ff == '0;

   always_comb begin
      refuse = 1'b0;
      occ_in = occ_ff;
      case (req_item.command)
         CMD_APPEND, CMD_INSERT: begin
            refuse = full;
            if (!full) occ_in = occ_ff + CW'(1);
         end
         CMD_REMOVE: begin
            refuse = empty;
            if (!empty) occ_in = occ_ff - CW'(1);
         end
         default: begin
            refuse = 1'b0;
         end
      endcase
   end

   always_comb begin
      ctl.value = req_item.value;
      ctl.op    = (take && !refuse) ? req_item.command : CMD_NONE;
   end

   assign pass[0] = 1'b1;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [ValueWidth-1:0] prev_slot;
      logic [ValueWidth-1:0] next_slot;
      if (i == 0) begin : g_first
         assign prev_slot = req_item.value;
      end else begin : g_mid
         assign prev_slot = slot_q[i-1];
      end
      if (i == DEPTH-1) begin : g_last
         assign next_slot = slot_q[i];
      end else begin : g_inner
         assign next_slot = slot_q[i+1];
      end
      siq_cell #(
         .DEPTH (DEPTH),
         .IDX   (i)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .occ       (occ_ff),
         .prev_slot (prev_slot),
         .next_slot (next_slot),
         .pass_in   (pass[i]),
         .pass_out  (pass[i+1]),
         .slot_q    (slot_q[i]),
         .slot_next (slot_next[i])
      );
   end

   always_comb begin
      rsp_in.front_value = (occ_in != '0) ? slot_next[0] : '0;
      rsp_in.count       = CountWidth'(occ_in);
      rsp_in.empty_res   = occ_in == '0;
      rsp_in.full_res    = occ_in == CW'(DEPTH);
      rsp_in.refused     = refuse;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= take;
         if (take) occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) rsp_ff <= rsp_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

`default_nettype wire

>>> rtl/siq_checker.sv
// Port-level checks for the sorted insert queue, bound to the top level.
`default_nettype none

module siq_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic        busy,
   input  wire logic        rsp_valid,
   input  wire siq_pkg::rsp_type rsp_item
);
   import siq_pkg::*;

   // Every accepted transaction gives a result in the next cycle.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_valid)
      else $error("accepted transaction gave no result");

   // No result appears without a transaction in the cycle before.
   a_no_stray_result: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |=> !rsp_valid)
      else $error("result without a transaction");

   // An empty queue shows no front entry, no count and is not full.
   a_empty_consistent: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.empty_res) |->
         (rsp_item.front_value == '0 && rsp_item.count == '0 && !rsp_item.full_res))
      else $error("empty result carries data");

   // Nothing comes out in the cycle after reset.
   a_quiet_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result right after reset");

endmodule

bind sorted_insert_queue_unit siq_checker u_siq_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);

`default_nettype wire
